FILE: rtl/tcd_pkg.sv
// Shared types, constants and helper functions for the tempo clock block.
// No dependencies; imported by tcd_engine and tempo_clock_with_dividers_core.
package tcd_pkg;

  // Fixed field widths
  localparam int unsigned PeriodW   = 26;
  localparam int unsigned PulseW    = 16;
  localparam int unsigned PhaseW    = 27;
  localparam int unsigned CfgDataW  = 26;
  localparam int unsigned LevelsW   = 8;
  localparam int unsigned StepOutW  = 3;
  localparam int unsigned StepExtW  = 5;

  // Divider count range and default
  localparam int unsigned DIVIDER_OUTPUTS_DEF = 8;
  localparam int unsigned DIVIDER_OUTPUTS_MAX = 16;

  // Phase arithmetic, 8 fraction bits
  localparam logic [PhaseW-1:0] PhaseMax = {PhaseW{1'b1}};
  localparam logic [PhaseW-1:0] OneTick  = PhaseW'(256);

  // Register reset values
  localparam logic [PeriodW-1:0] PeriodRst = PeriodW'(3072000);
  localparam logic [PulseW-1:0]  PulseRst  = PulseW'(48);

  typedef enum logic [0:0] {
    CFG_HALF_BEAT_PERIOD = 1'b0,
    CFG_PULSE_TICKS      = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PeriodW-1:0] half_beat_period_q8;
    logic [PulseW-1:0]  pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic                reset_pulse;
    logic                clock_pulse;
    logic [LevelsW-1:0]  divider_levels;
    logic [StepOutW-1:0] step_index;
  } result_t;

  // Bit k set when step is a multiple of k+1; step is always small.
  function automatic logic [DIVIDER_OUTPUTS_MAX-1:0] step_hits(input logic [StepExtW-1:0] step);
    logic [DIVIDER_OUTPUTS_MAX-1:0] hits;
    hits = '0;
    for (int k = 0; k < DIVIDER_OUTPUTS_MAX; k++) begin
      for (int j = 0; j <= DIVIDER_OUTPUTS_MAX; j++) begin
        if (j * (k + 1) == int'(step)) begin
          hits[k] = 1'b1;
        end
      end
    end
    return hits;
  endfunction

endpackage

FILE: rtl/tempo_clock_with_dividers_core.sv
// Top level of the tempo clock with reset pulse and clock dividers.
// Depends on tcd_pkg and tcd_engine.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / run_i): one transaction per
//   sample tick. run_i = 1 runs the clock, run_i = 0 stops it, clears the
//   phase and step count and arms a reset pulse for the next running tick.
//   Output channel (out_valid_o / out_stall_i): exactly one transaction per
//   input transaction, in order, carrying the reset and clock trigger levels,
//   the divider levels (bit k divides by k+1) and the current step.
//   Configuration: cfg_we_i writes cfg_data_i to the register selected by
//   cfg_index_i (0: half-beat period in ticks, 8 fraction bits; 1: pulse
//   length in ticks). Write only while no transaction is in flight.
//   The path is an input register, then the tick update written into the
//   output register. Throughput is one transaction per cycle without stalls;
//   the tick update is one 27-bit compare, subtract and saturating add.
//   When the receiver stalls, the output register holds its transaction and
//   the input register fills; in_stall_o rises only when both are occupied.
//   Reset (rst_ni low) empties both stages, clears all tick state, arms the
//   reset pulse and loads the default period and pulse length.
module tempo_clock_with_dividers_core #(
  parameter int unsigned DividerOutputs = tcd_pkg::DIVIDER_OUTPUTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           run_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           reset_pulse_o,
  output logic                           clock_pulse_o,
  output logic [tcd_pkg::LevelsW-1:0]    divider_levels_o,
  output logic [tcd_pkg::StepOutW-1:0]   step_index_o,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_index_i,
  input  logic [tcd_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tcd_pkg::*;

  // Configuration registers
  cfg_t     cfg_q;
  cfg_idx_e cfg_idx;

  assign cfg_idx = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_beat_period_q8 <= PeriodRst;
      cfg_q.pulse_ticks         <= PulseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_HALF_BEAT_PERIOD: cfg_q.half_beat_period_q8 <= cfg_data_i[PeriodW-1:0];
        CFG_PULSE_TICKS:      cfg_q.pulse_ticks         <= cfg_data_i[PulseW-1:0];
      endcase
    end
  end

  // Input stage: hold the run flag of one transaction
  logic    in_valid_q;
  logic    run_q;
  logic    out_valid_q;
  logic    out_busy;
  logic    advance;
  logic    in_take;
  result_t result;
  result_t out_q;

  assign out_busy   = out_valid_q & out_stall_i;
  assign advance    = in_valid_q & ~out_busy;
  assign in_stall_o = in_valid_q & out_busy;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      run_q <= run_i;
    end
  end

  // Tick update; state advances when the transaction moves to the output
  tcd_engine #(
    .DividerOutputs(DividerOutputs)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .run_i    (run_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reset_pulse_o    = out_q.reset_pulse;
  assign clock_pulse_o    = out_q.clock_pulse;
  assign divider_levels_o = out_q.divider_levels;
  assign step_index_o     = out_q.step_index;

  // A stalled input side means both stages hold a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a full pipeline");

  // A stopped tick always arms the reset pulse and clears the step
  a_stop_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !run_q) |=> (u_engine.armed_q && (u_engine.step_q == '0)))
    else $error("stop did not rearm the restart");

  // The step count only moves when a transaction advances
  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(u_engine.step_q))
    else $error("step count changed without a transaction");

  // Hold a stalled output transaction unchanged until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output transaction changed");

endmodule

FILE: rtl/tcd_engine.sv
// Tick state of the tempo clock: phase accumulator, step counter, pulse timers
// and divider levels. Depends on tcd_pkg.
module tcd_engine #(
  parameter int unsigned DividerOutputs = tcd_pkg::DIVIDER_OUTPUTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            run_i,
  input  tcd_pkg::cfg_t   cfg_i,
  output tcd_pkg::result_t result_o
);
  import tcd_pkg::*;

  localparam int unsigned StepW = $clog2(DividerOutputs);
  localparam logic [StepW-1:0] StepLast = StepW'(DividerOutputs - 1);

  logic [PhaseW-1:0]         phase_q, phase_d, phase_sub;
  logic [StepW-1:0]          step_q, step_d;
  logic                      armed_q, armed_d;
  logic [PulseW-1:0]         reset_rem_q, reset_rem_d, reset_rem_t;
  logic [PulseW-1:0]         clock_rem_q, clock_rem_d, clock_rem_t;
  logic                      reset_lvl_q, reset_lvl_d;
  logic                      clock_lvl_q, clock_lvl_d;
  logic [DividerOutputs-1:0] held_q, held_d;
  logic                      fire;
  logic [DIVIDER_OUTPUTS_MAX-1:0] hits;
  logic [DIVIDER_OUTPUTS_MAX-1:0] held_ext;

  always_comb begin
    phase_d     = phase_q;
    step_d      = step_q;
    armed_d     = armed_q;
    reset_rem_d = reset_rem_q;
    clock_rem_d = clock_rem_q;
    reset_lvl_d = reset_lvl_q;
    clock_lvl_d = clock_lvl_q;
    held_d      = held_q;
    fire        = 1'b0;
    phase_sub   = phase_q;
    reset_rem_t = reset_rem_q;
    clock_rem_t = clock_rem_q;
    hits        = '0;
    if (run_i) begin
      // Reset pulse on the first running tick after a stop
      if (armed_q && (cfg_i.pulse_ticks > reset_rem_q)) begin
        reset_rem_t = cfg_i.pulse_ticks;
      end
      armed_d     = 1'b0;
      reset_lvl_d = (reset_rem_t != '0);
      reset_rem_d = reset_rem_t - PulseW'(reset_lvl_d);

      // Clock fires once the phase passes the half-beat period
      fire = (phase_q > PhaseW'(cfg_i.half_beat_period_q8));
      if (fire) begin
        phase_sub = phase_q - PhaseW'(cfg_i.half_beat_period_q8);
        step_d    = (step_q == StepLast) ? '0 : step_q + StepW'(1);
        if (cfg_i.pulse_ticks > clock_rem_q) begin
          clock_rem_t = cfg_i.pulse_ticks;
        end
      end
      phase_d = (phase_sub > (PhaseMax - OneTick)) ? PhaseMax : phase_sub + OneTick;

      clock_lvl_d = (clock_rem_t != '0);
      clock_rem_d = clock_rem_t - PulseW'(clock_lvl_d);

      hits = step_hits(StepExtW'(step_d));
      for (int k = 0; k < DividerOutputs; k++) begin
        if (hits[k]) begin
          held_d[k] = clock_lvl_d;
        end
      end
    end else begin
      phase_d = '0;
      step_d  = '0;
      armed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      step_q      <= '0;
      armed_q     <= 1'b1;
      reset_rem_q <= '0;
      clock_rem_q <= '0;
      reset_lvl_q <= 1'b0;
      clock_lvl_q <= 1'b0;
      held_q      <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      armed_q     <= armed_d;
      reset_rem_q <= reset_rem_d;
      clock_rem_q <= clock_rem_d;
      reset_lvl_q <= reset_lvl_d;
      clock_lvl_q <= clock_lvl_d;
      held_q      <= held_d;
    end
  end

  assign held_ext = DIVIDER_OUTPUTS_MAX'(held_d);

  always_comb begin
    logic [StepExtW-1:0] step_ext;
    step_ext                = StepExtW'(step_d);
    result_o.reset_pulse    = reset_lvl_d;
    result_o.clock_pulse    = clock_lvl_d;
    result_o.divider_levels = held_ext[LevelsW-1:0];
    result_o.step_index     = step_ext[StepOutW-1:0];
  end

endmodule
